### rtl/bsrm_pkg.sv
// shared types and codes for the backing-store range map
package bsrm_pkg;

	localparam int PID_W    = 8;
	localparam int ADDR_W   = 32;
	localparam int PAGE_W   = 20;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int OFF_W    = 8;
	localparam int PAGE_SHIFT = 12;

	localparam logic REQ_MAP    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd3;

	typedef struct packed {
		logic               req_type;
		logic [PID_W-1:0]   owner_pid;
		logic [ADDR_W-1:0]  virtual_address;
		logic [PAGE_W-1:0]  base_page;
		logic [SLOT_W-1:0]  target_store;
		logic [COUNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   found_store;
		logic [OFF_W-1:0]    page_offset;
	} res_t;

	typedef struct packed {
		logic [PID_W-1:0]   owner;
		logic [PAGE_W-1:0]  base;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic write;
		logic issue;
		logic fin_map;
		logic fin_look;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
	} sts_t;

endpackage

### rtl/bsrm_datapath.sv
// table memory, scan pipeline and result register of the range map
module bsrm_datapath #(
	parameter int STORES    = 16,
	parameter int MAX_PAGES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bsrm_pkg::req_t req,
	input  bsrm_pkg::cmd_t cmd,
	output bsrm_pkg::sts_t sts,
	output bsrm_pkg::res_t res
);
	import bsrm_pkg::*;

	localparam int IDX_W = (STORES > 1) ? $clog2(STORES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORES - 1);

	req_t             req_q;
	logic [IDX_W-1:0] cnt_q;
	logic [STORES-1:0] valid_q;
	entry_t           mem [STORES];

	logic             live_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             rd_valid_s1;
	entry_t           rd_entry_s1;

	res_t             res_q;

	logic              wr_ok;
	logic [IDX_W-1:0]  wr_addr;
	logic [PAGE_W-1:0] page;
	logic [PAGE_W:0]   range_end;
	logic [PAGE_W-1:0] off;
	logic              hit;

	assign wr_ok   = 32'(req_q.target_store) < 32'(STORES);
	assign wr_addr = IDX_W'(req_q.target_store);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= '0;
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= cmd.issue;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.issue && cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmd.write && wr_ok) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write && wr_ok) begin
			mem[wr_addr] <= '{owner: req_q.owner_pid, base: req_q.base_page,
				count: req_q.page_count};
		end
		if (cmd.issue) begin
			rd_entry_s1 <= mem[cnt_q];
			rd_valid_s1 <= valid_q[cnt_q];
			idx_s1      <= cnt_q;
		end
	end

	assign page      = req_q.virtual_address[ADDR_W-1:PAGE_SHIFT];
	assign range_end = {1'b0, rd_entry_s1.base} + (PAGE_W + 1)'(rd_entry_s1.count);
	assign off       = page - rd_entry_s1.base;

	assign hit = live_s1 && rd_valid_s1 && rd_entry_s1.owner == req_q.owner_pid
		&& page >= rd_entry_s1.base && {1'b0, page} < range_end;

	assign sts.hit  = hit;
	assign sts.last = live_s1 && idx_s1 == LAST_IDX;

	always_ff @(posedge clk) begin
		if (cmd.fin_map) begin
			res_q <= '{status: ST_MAPPED, found_store: '0, page_offset: '0};
		end else if (cmd.fin_look) begin
			if (hit) begin
				res_q.status      <= (off > PAGE_W'(MAX_PAGES)) ? ST_LIMIT : ST_FOUND;
				res_q.found_store <= SLOT_W'(idx_s1);
				res_q.page_offset <= off[OFF_W-1:0];
			end else begin
				res_q <= '{status: ST_MISS, found_store: '0, page_offset: '0};
			end
		end
	end

	assign res = res_q;

endmodule

### rtl/bsrm_ctrl.sv
// sequencer for map writes and lookup scans
module bsrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           req_type,
	input  bsrm_pkg::sts_t sts,
	output bsrm_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);
	import bsrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WRITE = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (req_type == REQ_MAP) ? S_WRITE : S_SCAN;
				end
			end
			S_WRITE: begin
				cmd.write   = 1'b1;
				cmd.fin_map = 1'b1;
				done_d      = 1'b1;
				state_d     = S_IDLE;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				// first match or the last entry ends the scan
				if (sts.hit || sts.last) begin
					cmd.fin_look = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

### rtl/backing_store_range_map_top.sv
// Backing-store range map. A word is taken when start is high and busy is low.
// A map word writes one table entry; its result shows on res with done high once
// the entry is written. A lookup scans the table one entry per cycle
// through the single read port of the table memory: the scan ends at the lowest
// matching entry, or after the last entry on a miss. The result is flagged by done for
// exactly one cycle and cannot be stalled; busy is already low in that cycle, so
// the next word may be started while it is shown.
module backing_store_range_map_top #(
	parameter int STORES    = 16,
	parameter int MAX_PAGES = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bsrm_pkg::req_t req,
	output logic           done,
	output bsrm_pkg::res_t res
);
	import bsrm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bsrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	bsrm_datapath #(
		.STORES    (STORES),
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

### rtl/bsrm_checker.sv
// port-level checks for the range map, bound to the top level
module bsrm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input bsrm_pkg::res_t res
);
	import bsrm_pkg::*;

	// an accepted word always keeps the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result shown for more than one cycle");

	// the block frees up exactly when a result comes out
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without preceding work");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.status == ST_MAPPED || res.status == ST_MISS)
		|-> res.found_store == '0 && res.page_offset == '0)
		else $error("map or miss result carries nonzero fields");

endmodule

bind backing_store_range_map_top bsrm_checker u_bsrm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

### tb/tb_backing_store_range_map_top.sv
// testbench for the backing-store range map: directed and random words against a shadow table
module tb_backing_store_range_map_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bsrm_pkg::*;

	localparam int STORES    = 16;
	localparam int MAX_PAGES = 128;
	localparam int RANDOM_WORDS = 675;
	localparam int MAX_PRINTS = 40;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t res;

	backing_store_range_map_top #(
		.STORES(STORES),
		.MAX_PAGES(MAX_PAGES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	req_t   word_q[$];
	res_t   answer_q[$];

	// shadow of the table as the block sees it, updated at acceptance
	logic   map_valid[STORES];
	entry_t map_entry[STORES];
	// copy used only to aim generated lookups at live ranges
	entry_t plan_entry[STORES];

	int errors;
	int accepted;
	int total_words;
	int n_map, n_found, n_miss, n_limit;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic res_t translate(input req_t r);
		res_t             o;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W:0]   range_end;
		logic [PAGE_W-1:0] offset;
		o.status      = ST_MAPPED;
		o.found_store = '0;
		o.page_offset = '0;
		if (r.req_type == REQ_MAP) begin
			if (r.target_store < STORES) begin
				map_valid[r.target_store]       = 1'b1;
				map_entry[r.target_store].owner = r.owner_pid;
				map_entry[r.target_store].base  = r.base_page;
				map_entry[r.target_store].count = r.page_count;
			end
		end else begin
			page = r.virtual_address[ADDR_W-1:PAGE_SHIFT];
			o.status = ST_MISS;
			for (int i = 0; i < STORES; i++) begin
				if (map_valid[i] && map_entry[i].owner == r.owner_pid) begin
					// range end is one bit wider so it never wraps
					range_end = {1'b0, map_entry[i].base}
						+ (PAGE_W + 1)'(map_entry[i].count);
					if (page >= map_entry[i].base && {1'b0, page} < range_end) begin
						offset = page - map_entry[i].base;
						o.found_store = i[SLOT_W-1:0];
						o.page_offset = offset[OFF_W-1:0];
						o.status = (offset > MAX_PAGES) ? ST_LIMIT : ST_FOUND;
						break;
					end
				end
			end
		end
		return o;
	endfunction

	function automatic logic [PID_W-1:0] pick_pid();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			default: return PID_W'($urandom_range(255));
		endcase
	endfunction

	task automatic add_map(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] base,
			input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count);
		req_t r;
		r.req_type        = REQ_MAP;
		r.owner_pid       = pid;
		r.virtual_address = $urandom;
		r.base_page       = base;
		r.target_store    = slot;
		r.page_count      = count;
		plan_entry[slot].owner = pid;
		plan_entry[slot].base  = base;
		plan_entry[slot].count = count;
		word_q.push_back(r);
	endtask

	task automatic add_lookup(input logic [PID_W-1:0] pid, input logic [ADDR_W-1:0] addr);
		req_t r;
		r.req_type        = REQ_LOOKUP;
		r.owner_pid       = pid;
		r.virtual_address = addr;
		r.base_page       = PAGE_W'($urandom);
		r.target_store    = SLOT_W'($urandom);
		r.page_count      = COUNT_W'($urandom);
		word_q.push_back(r);
	endtask

	task automatic build_words();
		int             pick;
		int             pg;
		entry_t         e;
		logic [PAGE_W-1:0]  base;
		logic [COUNT_W-1:0] count;
		// fill every entry first so no scan ever touches an unwritten one
		add_map(8'hFF, 20'hFFFFF, 4'd0, 8'hFF);
		add_map(8'h00, 20'h00000, 4'd1, 8'h00);
		add_map(8'h00, 20'h00000, 4'd2, 8'hFF);
		add_map(8'h05, 20'h00100, 4'd3, 8'hC8);
		add_map(8'h05, 20'h00100, 4'd4, 8'h0A);
		for (int i = 5; i < STORES; i++)
			add_map(PID_W'($urandom_range(16, 250)), PAGE_W'($urandom),
				i[SLOT_W-1:0], COUNT_W'($urandom));
		add_lookup(8'hFF, 32'hFFFF_FFFF);             // top page, range past the end
		add_lookup(8'h00, 32'h0000_0000);             // empty entry skipped
		add_lookup(8'h00, {20'd254, 12'hFFF});        // last page of a full range
		add_lookup(8'h05, {20'h00180, 12'h000});      // offset right at the limit
		add_lookup(8'h05, {20'h00181, 12'h000});      // one past the limit
		add_lookup(8'h05, {20'h000FF, 12'hFFF});      // just below the base
		add_lookup(8'h05, {20'h00109, 12'h800});      // lower index shadows a later match
		add_map(8'h00, 20'h80000, 4'd2, 8'h01);       // remap a live entry
		add_lookup(8'h00, 32'h0000_0000);
		add_lookup(8'h00, {20'h80000, 12'h123});

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				base = ($urandom_range(3) == 0) ? PAGE_W'($urandom_range(20'hFFFFF, 20'hFFF00))
					: PAGE_W'($urandom_range(20'hFFFFF));
				case ($urandom_range(7))
					0:       count = '0;
					1, 2:    count = COUNT_W'($urandom_range(255, 129));
					default: count = COUNT_W'($urandom_range(255));
				endcase
				add_map(pick_pid(), base, SLOT_W'($urandom), count);
			end else if (pick < 85) begin
				// aim at a live range, sometimes a page or two past its end
				e  = plan_entry[$urandom_range(STORES - 1)];
				pg = int'(e.base) + $urandom_range(int'(e.count) + 1);
				if (pg > 'hFFFFF)
					pg = 'hFFFFF;
				add_lookup(e.owner, {pg[PAGE_W-1:0], 12'($urandom)});
			end else begin
				add_lookup(PID_W'($urandom), $urandom);
			end
		end
	endtask

	function automatic int idle_percent(input int done_words);
		case (done_words * 4 / total_words)
			1:       return 58;
			2:       return 21;
			default: return 0;
		endcase
	endfunction

	// driver: hold the word until busy is low, then take the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				answer_q.push_back(translate(req));
				accepted++;
			end
			if (!start || !busy) begin
				if (word_q.size() != 0 && $urandom_range(99) >= idle_percent(accepted)) begin
					start <= 1'b1;
					req   <= word_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: each result lives for one cycle, check it at the edge that ends it
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				mismatch($sformatf("unexpected result %p", res));
			end else begin
				want = answer_q.pop_front();
				if (res.status !== want.status)
					mismatch($sformatf("status %0d, want %0d", res.status, want.status));
				if (res.found_store !== want.found_store)
					mismatch($sformatf("found_store %0d, want %0d", res.found_store,
						want.found_store));
				if (res.page_offset !== want.page_offset)
					mismatch($sformatf("page_offset %0d, want %0d", res.page_offset,
						want.page_offset));
				case (want.status)
					ST_MAPPED: n_map++;
					ST_FOUND:  n_found++;
					ST_MISS:   n_miss++;
					default:   n_limit++;
				endcase
			end
		end
	end

	initial begin
		errors = 0;
		accepted = 0;
		n_map = 0;
		n_found = 0;
		n_miss = 0;
		n_limit = 0;
		arst_n = 1'b0;
		for (int i = 0; i < STORES; i++) begin
			map_valid[i] = 1'b0;
			map_entry[i] = '0;
			plan_entry[i] = '0;
		end
		build_words();
		total_words = word_q.size();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (accepted == total_words);
		wait (answer_q.size() == 0);
		repeat (STORES + 4) @(posedge clk);
		$display("%0d words sent: %0d maps, %0d found, %0d not found, %0d beyond limit",
			total_words, n_map, n_found, n_miss, n_limit);
		$display("sender gaps ran at 0, 58 and 21 percent; %0d mismatches", errors);
		if (errors == 0)
			$display("tb_backing_store_range_map_top OK");
		else
			$display("tb_backing_store_range_map_top NOT OK");
		$finish;
	end

	initial begin
		#500000;
		$display("timeout");
		$display("tb_backing_store_range_map_top NOT OK");
		$finish;
	end

endmodule
